/* rtl/core/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int AtanTableLen = 24;
   localparam int FracBits     = 14;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
   } axis_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } matrix_type;

   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] v;
      v = '0;
      unique case (idx)
         0:  v = 34'sd536870912;
         1:  v = 34'sd316933406;
         2:  v = 34'sd167458907;
         3:  v = 34'sd85004756;
         4:  v = 34'sd42667331;
         5:  v = 34'sd21354465;
         6:  v = 34'sd10679838;
         7:  v = 34'sd5340245;
         8:  v = 34'sd2670163;
         9:  v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/aarm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// one registered cordic micro-rotation, carrying the axis alongside
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                valid_in,
   input  aarm_pkg::cordic_type cor_in,
   input  aarm_pkg::axis_type  axis_in,
   output logic                valid_out,
   output aarm_pkg::cordic_type cor_out,
   output aarm_pkg::axis_type  axis_out
);
   import aarm_pkg::*;

   localparam logic signed [33:0] Atan = atan_entry(STEP);

   logic                valid_ff;
   cordic_type          cor_ff, cor_in_nxt;
   axis_type            axis_ff;
   logic signed [33:0]  xs, ys;

   always_comb begin
      xs = cor_in.x >>> STEP;
      ys = cor_in.y >>> STEP;
      cor_in_nxt.flip = cor_in.flip;
      if (!cor_in.z[33]) begin
         cor_in_nxt.x = cor_in.x - ys;
         cor_in_nxt.y = cor_in.y + xs;
         cor_in_nxt.z = cor_in.z - Atan;
      end else begin
         cor_in_nxt.x = cor_in.x + ys;
         cor_in_nxt.y = cor_in.y - xs;
         cor_in_nxt.z = cor_in.z + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         cor_ff  <= cor_in_nxt;
         axis_ff <= axis_in;
      end
   end

   assign valid_out = valid_ff;
   assign cor_out   = cor_ff;
   assign axis_out  = axis_ff;
endmodule

/* rtl/core/aarm_matrix.sv */
// ----------------------------------------------------------------------------
// aarm_matrix
// rounds sine and cosine and forms the rodrigues entries over four stages
// ----------------------------------------------------------------------------
module aarm_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 valid_in,
   input  aarm_pkg::cordic_type cor_in,
   input  aarm_pkg::axis_type   axis_in,
   output logic                 valid_out,
   output aarm_pkg::matrix_type mat_out
);
   import aarm_pkg::*;

   localparam int Sh1 = 30 - FracBits;
   localparam int Sh2 = 2 * FracBits;

   // stage 1: c, s, t
   logic [3:0]          valid_ff;
   logic signed [34:0]  cx, sy, cr, sr;
   logic signed [19:0]  c_ff, s_ff;
   logic signed [20:0]  t_ff;
   axis_type            ax1_ff, ax2_ff;

   always_comb begin
      cx = cor_in.flip ? -{cor_in.x[33], cor_in.x} : {cor_in.x[33], cor_in.x};
      sy = cor_in.flip ? -{cor_in.y[33], cor_in.y} : {cor_in.y[33], cor_in.y};
      cr = (cx + (35'sd1 <<< (Sh1 - 1))) >>> Sh1;
      sr = (sy + (35'sd1 <<< (Sh1 - 1))) >>> Sh1;
   end

   // stage 2: axis*t, axis*s
   logic signed [37:0]  xt_ff, yt_ff, zt_ff;
   logic signed [36:0]  xs_ff, ys_ff, zs_ff;
   logic signed [19:0]  c2_ff, c3_ff;
   // stage 3: triple products, rounded on the way into stage 4
   logic signed [54:0]  xx, xy, xz, yy, yz, zz;
   logic signed [54:0]  xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   logic signed [36:0]  xs3_ff, ys3_ff, zs3_ff;
   matrix_type          mat_ff;

   function automatic logic signed [15:0] sat(input logic signed [55:0] v);
      if (v > 56'sd32767) return 16'sh7fff;
      if (v < -56'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   always_comb begin
      xx = (xx_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
      xy = (xy_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
      xz = (xz_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
      yy = (yy_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
      yz = (yz_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
      zz = (zz_ff + (55'sd1 <<< (Sh2 - 1))) >>> Sh2;
   end

   logic signed [36:0] xsr, ysr, zsr;
   always_comb begin
      xsr = (xs3_ff + (37'sd1 <<< (FracBits - 1))) >>> FracBits;
      ysr = (ys3_ff + (37'sd1 <<< (FracBits - 1))) >>> FracBits;
      zsr = (zs3_ff + (37'sd1 <<< (FracBits - 1))) >>> FracBits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], valid_in};
      end
      if (enable) begin
         c_ff   <= cr[19:0];
         s_ff   <= sr[19:0];
         t_ff   <= 21'((35'sd1 <<< FracBits) - cr);
         ax1_ff <= axis_in;
         xt_ff  <= 38'(ax1_ff.ax * t_ff);
         yt_ff  <= 38'(ax1_ff.ay * t_ff);
         zt_ff  <= 38'(ax1_ff.az * t_ff);
         xs_ff  <= 37'(ax1_ff.ax * s_ff);
         ys_ff  <= 37'(ax1_ff.ay * s_ff);
         zs_ff  <= 37'(ax1_ff.az * s_ff);
         c2_ff  <= c_ff;
         ax2_ff <= ax1_ff;
         xx_ff  <= 55'(ax2_ff.ax * xt_ff);
         xy_ff  <= 55'(ax2_ff.ax * yt_ff);
         xz_ff  <= 55'(ax2_ff.ax * zt_ff);
         yy_ff  <= 55'(ax2_ff.ay * yt_ff);
         yz_ff  <= 55'(ax2_ff.ay * zt_ff);
         zz_ff  <= 55'(ax2_ff.az * zt_ff);
         xs3_ff <= xs_ff;
         ys3_ff <= ys_ff;
         zs3_ff <= zs_ff;
         c3_ff  <= c2_ff;
         mat_ff.r00 <= sat(56'(xx) + 56'(c3_ff));
         mat_ff.r01 <= sat(56'(xy) + 56'(zsr));
         mat_ff.r02 <= sat(56'(xz) - 56'(ysr));
         mat_ff.r10 <= sat(56'(xy) - 56'(zsr));
         mat_ff.r11 <= sat(56'(yy) + 56'(c3_ff));
         mat_ff.r12 <= sat(56'(yz) + 56'(xsr));
         mat_ff.r20 <= sat(56'(xz) + 56'(ysr));
         mat_ff.r21 <= sat(56'(yz) - 56'(xsr));
         mat_ff.r22 <= sat(56'(zz) + 56'(c3_ff));
      end
   end

   assign valid_out = valid_ff[3];
   assign mat_out   = mat_ff;
endmodule

/* rtl/core/axis_angle_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// rodrigues rotation matrix from axis and binary angle, cordic sine/cosine
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)
// req     | in  | axis_x, axis_y, axis_z, turn_angle (16 bits each)
// rsp     | out | r00 r01 r02 r10 r11 r12 r20 r21 r22 (16 bits each)
// one request per cycle while the pipeline advances
// the cordic cell row and the four matrix stages form one pipeline
// the whole pipeline advances when the result register is empty or taken
// synchronous reset empties the pipeline
module axis_angle_rotation_matrix #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // axis_x, axis_y, axis_z, turn_angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata    // r00 r01 r02 r10 r11 r12 r20 r21 r22
);
   import aarm_pkg::*;

   localparam int Steps = (CORDIC_STEPS < AtanTableLen) ? CORDIC_STEPS : AtanTableLen;

   logic        enable;
   logic [31:0] z32, zf;
   logic        flip;
   logic        rsp_valid_ff, mat_valid;
   matrix_type  mat, rsp_ff;

   logic       vl [Steps+1];
   cordic_type cl [Steps+1];
   axis_type   al [Steps+1];

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;

   always_comb begin
      z32   = {req_tdata[63:48], 16'h0000};
      flip  = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
      zf    = flip ? (z32 + 32'h8000_0000) : z32;
   end

   assign vl[0] = req_tvalid;
   assign cl[0] = '{x: CordicGain, y: '0, z: {{2{zf[31]}}, zf}, flip: flip};
   assign al[0] = '{ax: req_tdata[15:0], ay: req_tdata[31:16], az: req_tdata[47:32]};

   for (genvar i = 0; i < Steps; i++) begin : g_cell
      aarm_cordic_cell #(.STEP(i)) u_cell (
         .clock, .reset, .enable,
         .valid_in(vl[i]), .cor_in(cl[i]), .axis_in(al[i]),
         .valid_out(vl[i+1]), .cor_out(cl[i+1]), .axis_out(al[i+1])
      );
   end

   aarm_matrix u_matrix (
      .clock, .reset, .enable,
      .valid_in(vl[Steps]), .cor_in(cl[Steps]), .axis_in(al[Steps]),
      .valid_out(mat_valid), .mat_out(mat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= mat_valid;
      end
      if (enable && mat_valid) begin
         rsp_ff <= mat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.r22, rsp_ff.r21, rsp_ff.r20, rsp_ff.r12, rsp_ff.r11,
                        rsp_ff.r10, rsp_ff.r02, rsp_ff.r01, rsp_ff.r00};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
endmodule
